FILE: hdl/bpbc_pkg.sv
// package: types and constants for the buffer provenance bounds checker
package bpbc_pkg;

  localparam int MaxBuffers = 64;
  localparam int IdW        = $clog2(MaxBuffers);
  localparam int AddrW      = 64;
  localparam int NumRegions = 3;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  // one table row: base, size, region
  localparam int RowW       = AddrW + 64 + 2;

  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree  = 2'd1;
  localparam logic [1:0] CmdCheck = 2'd2;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNoRegion = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  localparam logic [2:0] VerOk       = 3'd0;
  localparam logic [2:0] VerUaf      = 3'd1;
  localparam logic [2:0] VerCross    = 3'd2;
  localparam logic [2:0] VerOverflow = 3'd3;
  localparam logic [2:0] VerUnder    = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgEnable = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  region_id;
    logic [63:0] addr;
    logic [63:0] length;
    logic [5:0]  pointer_id;
  } req_t;

  typedef struct packed {
    logic [5:0]  result_id;
    logic [1:0]  op_status;
    logic [2:0]  verdict;
    logic [63:0] distance;
    logic [1:0]  land_region;
  } rsp_t;

endpackage

FILE: hdl/buffer_provenance_bounds_checker_core.sv
// top level: buffer table with allocate, free and access check
//
// A request is taken when start is high and busy is low; its answer shows
// on rsp_o with done_o high for one cycle, and the receiver cannot stall it.
// Buffer base, size and region live in one ram with a registered read; the
// freed and mapped marks are flip-flops so reset clears them at once.
// A check does one table read, then classifies and answers. Allocate and
// free sweep the ram one entry a cycle over the ids handed out; a free
// that finds its id stops there, and a free that misses answers not found.
// Requests with an undeclared region, a full table or an unknown command
// answer straight after the table read.
module buffer_provenance_bounds_checker_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  bpbc_pkg::req_t           req_i,
  output logic                     done_o,
  output bpbc_pkg::rsp_t           rsp_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [63:0]              cfg_data_i
);
  import bpbc_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SRead,
    SScan,
    SFinish
  } state_e;

  // configuration registers
  logic [63:0] rbase_q [NumRegions];
  logic [63:0] rsize_q [NumRegions];
  logic [NumRegions-1:0] ren_q;

  state_e       state_q;
  req_t         req_q;
  logic [IdW:0] next_id_q;          // one wider so it can hold the depth
  logic [IdW:0] scan_q;             // id being read in the sweep
  logic [MaxBuffers-1:0] freed_q, mapped_q;
  rsp_t         rsp_q;
  logic         done_q;

  // answer with only a status and an id
  function automatic rsp_t status_rsp(logic [1:0] st, logic [IdW-1:0] id);
    rsp_t r;
    r           = '0;
    r.op_status = st;
    r.result_id = id;
    return r;
  endfunction

  // table ram
  logic           ram_we;
  logic [IdW-1:0] ram_waddr, ram_raddr;
  logic [RowW-1:0] ram_wdata, ram_rdata;

  bpbc_ram #(.Width(RowW), .Depth(MaxBuffers)) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [63:0] e_base, e_size;
  logic [1:0]  e_region;
  assign e_base   = ram_rdata[RowW-1 -: 64];
  assign e_size   = ram_rdata[65:2];
  assign e_region = ram_rdata[1:0];

  // id read in the previous cycle
  logic [IdW-1:0] rd_id_q;

  // region declared check for the registered request
  logic rdecl;
  always_comb begin
    rdecl = 1'b0;
    for (int r = 0; r < NumRegions; r++) begin
      if (req_q.region_id == 2'(r) && ren_q[r]) rdecl = 1'b1;
    end
  end

  // landing region of the check address
  logic       land_hit;
  logic [1:0] land_r;
  always_comb begin
    land_hit = 1'b0;
    land_r   = 2'd0;
    for (int r = NumRegions - 1; r >= 0; r--) begin
      if (ren_q[r] && req_q.addr >= rbase_q[r] &&
          req_q.addr < (rbase_q[r] + rsize_q[r])) begin
        land_hit = 1'b1;
        land_r   = 2'(r);
      end
    end
  end

  // check classification from the entry just read
  logic [63:0] c_end, c_last;
  rsp_t        chk_rsp;
  always_comb begin
    c_end   = e_base + e_size;
    c_last  = req_q.addr + req_q.length;
    chk_rsp = '0;
    if (req_q.pointer_id != '0 && {1'b0, req_q.pointer_id} < next_id_q) begin
      if (freed_q[req_q.pointer_id]) begin
        chk_rsp.verdict = VerUaf;
      end else if (req_q.addr < e_base || c_last > c_end) begin
        if (land_hit && land_r != e_region) begin
          chk_rsp.verdict     = VerCross;
          chk_rsp.land_region = land_r;
        end else if (req_q.addr >= c_end) begin
          chk_rsp.verdict  = VerOverflow;
          chk_rsp.distance = req_q.addr - c_end;
        end else if (req_q.addr < e_base) begin
          chk_rsp.verdict  = VerUnder;
          chk_rsp.distance = e_base - req_q.addr;
        end else begin
          chk_rsp.verdict = VerOverflow;
        end
      end
    end
  end

  logic hit;
  assign hit = mapped_q[rd_id_q] && e_region == req_q.region_id && e_base == req_q.addr;

  assign busy   = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    ram_raddr = IdW'(scan_q);
    ram_we    = 1'b0;
    ram_waddr = next_id_q[IdW-1:0];
    ram_wdata = {req_q.addr, req_q.length, req_q.region_id};
    if (state_q == SIdle) ram_raddr = req_i.pointer_id;
    if (state_q == SFinish && req_q.cmd == CmdAlloc) ram_we = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      req_q     <= '0;
      next_id_q <= (IdW+1)'(1);
      scan_q    <= '0;
      rd_id_q   <= '0;
      freed_q   <= '0;
      mapped_q  <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
      ren_q     <= '0;
      for (int r = 0; r < NumRegions; r++) begin
        rbase_q[r] <= '0;
        rsize_q[r] <= '0;
      end
    end else begin
      done_q  <= 1'b0;
      rd_id_q <= ram_raddr;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgEnable) ren_q <= cfg_data_i[NumRegions-1:0];
        for (int r = 0; r < NumRegions; r++) begin
          if (cfg_idx_i == 3'(2 * r))     rbase_q[r] <= cfg_data_i;
          if (cfg_idx_i == 3'(2 * r + 1)) rsize_q[r] <= cfg_data_i;
        end
      end
      case (state_q)
        SIdle: begin
          if (start) begin
            req_q   <= req_i;
            scan_q  <= (IdW+1)'(1);
            state_q <= SRead;
          end
        end
        SRead: begin
          // ram holds the pointer's entry now
          if (req_q.cmd == CmdCheck) begin
            rsp_q   <= chk_rsp;
            done_q  <= 1'b1;
            state_q <= SIdle;
          end else if (req_q.cmd == CmdAlloc || req_q.cmd == CmdFree) begin
            if (!rdecl) begin
              rsp_q   <= status_rsp(StNoRegion, '0);
              done_q  <= 1'b1;
              state_q <= SIdle;
            end else if (req_q.cmd == CmdAlloc &&
                         next_id_q >= (IdW+1)'(MaxBuffers)) begin
              rsp_q   <= status_rsp(StFull, '0);
              done_q  <= 1'b1;
              state_q <= SIdle;
            end else if (scan_q >= next_id_q) begin
              state_q <= SFinish;
            end else begin
              scan_q  <= scan_q + (IdW+1)'(1);
              state_q <= SScan;
            end
          end else begin
            rsp_q   <= '0;
            done_q  <= 1'b1;
            state_q <= SIdle;
          end
        end
        SScan: begin
          // rd_id_q entry is on the ram output
          if (hit) begin
            mapped_q[rd_id_q] <= 1'b0;
            if (req_q.cmd == CmdFree) begin
              freed_q[rd_id_q] <= 1'b1;
              rsp_q   <= status_rsp(StDone, rd_id_q);
              done_q  <= 1'b1;
              state_q <= SIdle;
            end
          end
          if (!(hit && req_q.cmd == CmdFree)) begin
            if (scan_q >= next_id_q) begin
              state_q <= SFinish;
            end else begin
              scan_q <= scan_q + (IdW+1)'(1);
            end
          end
        end
        SFinish: begin
          done_q  <= 1'b1;
          state_q <= SIdle;
          if (req_q.cmd == CmdAlloc) begin
            freed_q[next_id_q[IdW-1:0]]  <= 1'b0;
            mapped_q[next_id_q[IdW-1:0]] <= 1'b1;
            rsp_q     <= status_rsp(StDone, next_id_q[IdW-1:0]);
            next_id_q <= next_id_q + (IdW+1)'(1);
          end else begin
            rsp_q <= status_rsp(StNotFound, '0);
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // id counter never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q <= (IdW+1)'(MaxBuffers))
    else $error("next id past table depth");

  // a done pulse always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == SIdle)
    else $error("done outside idle");

  // a new id is always mapped once allocated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFinish && req_q.cmd == CmdAlloc) |=> mapped_q[rsp_q.result_id])
    else $error("allocated entry not mapped");

  // a nonzero result id comes only with a success status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.result_id != '0) |-> rsp_q.op_status == StDone)
    else $error("result id with error status");

endmodule

FILE: hdl/bpbc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bpbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
